// ----- hdl/pba_pkg.sv -----
// Shared types and constants of the page bitmap allocator.
`default_nettype none

package pba_pkg;

  // Default number of pages that the bitmap can hold.
  localparam int unsigned MaxPagesDef = 32768;

  // The bitmap is stored as words of this many pages.
  localparam int unsigned WordW = 64;
  localparam int unsigned OffW  = 6;

  // Widths of the transaction fields.
  localparam int unsigned PageW    = 15;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegTotalPages = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStartPage  = 2'd1;

  // Value of total_pages after reset.
  localparam logic [CfgDataW-1:0] TotalPagesRst = 16'd32768;

  typedef enum logic [1:0] {
    FuncAlloc = 2'd0,
    FuncRun   = 2'd1,
    FuncLock  = 2'd2,
    FuncFree  = 2'd3
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [PageW-1:0]  page_index;
    logic [CountW-1:0] count;
  } req_t;

  typedef struct packed {
    logic [PageW-1:0] first_page;
    logic             ok;
  } rsp_t;

endpackage

`default_nettype wire

// ----- hdl/pba_bitmap.sv -----
// Bitmap word memory of the page allocator, with its clearing pass after reset.
`default_nettype none

module pba_bitmap #(
  parameter int unsigned WORDS  = pba_pkg::MaxPagesDef / pba_pkg::WordW,
  parameter int unsigned ADDR_W = 9
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     wr_en_i,
  input  wire logic [ADDR_W-1:0]        wr_addr_i,
  input  wire logic [pba_pkg::WordW-1:0] wr_data_i,
  input  wire logic [ADDR_W-1:0]        rd_addr_i,
  output logic      [pba_pkg::WordW-1:0] rd_data_o,
  output logic                          ready_o
);

  localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(WORDS - 1);

  logic [pba_pkg::WordW-1:0] mem [WORDS];

  logic              clr_q, clr_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

  logic                      we;
  logic [ADDR_W-1:0]         waddr;
  logic [pba_pkg::WordW-1:0] wdata;

  // The sweep writes one zero word per cycle until the last word is done.
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == LastAddr) begin
        clr_d      = 1'b0;
        clr_addr_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign we    = clr_q | wr_en_i;
  assign waddr = clr_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

  assign ready_o = ~clr_q;

endmodule

`default_nettype wire

// ----- hdl/page_bitmap_allocator.sv -----
// Top level of the page bitmap allocator: sequencer, registers and bitmap memory.
// After reset a clearing pass zeroes the bitmap, one word a cycle (512 words at the default
// size); busy stays high throughout. A command needing no scan answers in the next cycle.
// Otherwise each bitmap word is read through the Fetch and Fill states and written back in
// Flush when changed; each page examined or marked takes its own Step, and a fully used word
// is passed in one step. Busy also covers the result cycle; done_o cannot stall.
`default_nettype none

module page_bitmap_allocator #(
  parameter int unsigned MAX_PAGES = pba_pkg::MaxPagesDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Command channel.
  input  wire logic                            start,
  output logic                                 busy,
  input  wire pba_pkg::req_t                   req_i,
  // Result channel.
  output logic                                 done_o,
  output pba_pkg::rsp_t                        rsp_o,
  // Configuration write channel.
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [pba_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [pba_pkg::CfgDataW-1:0]    cfg_data_i
);

  // The bitmap holds one bit per page, packed into words of WordW pages.
  localparam int unsigned Words = (MAX_PAGES + pba_pkg::WordW - 1) / pba_pkg::WordW;
  localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam logic [31:0] MaxPagesW = 32'(MAX_PAGES);

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StFetch = 6'b000010,
    StFill  = 6'b000100,
    StStep  = 6'b001000,
    StFlush = 6'b010000,
    StDone  = 6'b100000
  } state_e;

  state_e st_q, st_d;

  // Configuration and search hint.
  logic [15:0] total_q, total_d;
  logic [15:0] hint_q, hint_d;

  // Working registers of the transaction in flight.
  pba_pkg::func_e            func_q, func_d;
  logic [15:0]               pos_q, pos_d;
  logic [15:0]               cnt_q, cnt_d;
  logic [15:0]               found_q, found_d;
  logic [15:0]               run_start_q, run_start_d;
  logic                      phase_q, phase_d;
  logic                      fin_q, fin_d;
  logic [pba_pkg::WordW-1:0] word_q, word_d;
  logic [AddrW-1:0]          waddr_q, waddr_d;
  logic [pba_pkg::PageW-1:0] first_q, first_d;
  logic                      ok_q, ok_d;

  // Bitmap memory interface.
  logic                      mem_we;
  logic [AddrW-1:0]          mem_addr;
  logic [pba_pkg::WordW-1:0] mem_rdata;
  logic                      mem_ready;

  // Datapath helpers around the current position.
  logic [15:0]              lim;
  logic [16:0]              lim17;
  logic [31:0]              pos_word;
  logic [pba_pkg::OffW-1:0] off;
  logic                     cur_bit;
  logic [16:0]              np17;
  logic [15:0]              np16;
  logic                     np_end;
  logic                     wrap;
  logic [16:0]              p64;
  logic [15:0]              skip_pos;
  logic                     skip_end;
  logic                     full_skip;
  logic [15:0]              found_inc;
  logic [15:0]              run_first;
  logic                     mark_val;
  logic [15:0]              pidx16;
  logic                     accept;
  logic                     cfg_we;

  // The page limit is total_pages saturated to the bitmap size.
  assign lim   = (32'(total_q) < MaxPagesW) ? total_q : MaxPagesW[15:0];
  assign lim17 = {1'b0, lim};

  assign pos_word = 32'(pos_q) >> pba_pkg::OffW;
  assign mem_addr = pos_word[AddrW-1:0];

  assign off     = pos_q[pba_pkg::OffW-1:0];
  assign cur_bit = word_q[off];
  assign wrap    = &off;

  // Next page, and whether the walk has run into the limit there.
  assign np17   = {1'b0, pos_q} + 17'd1;
  assign np16   = np17[15:0];
  assign np_end = (np17 >= lim17);

  // A word whose pages are all used is passed over in one step, never beyond the limit.
  assign p64       = {1'b0, pos_q} + 17'(pba_pkg::WordW);
  assign skip_pos  = (p64 > lim17) ? lim : p64[15:0];
  assign skip_end  = (skip_pos >= lim);
  assign full_skip = (off == '0) && (&word_q);

  assign found_inc = found_q + 16'd1;
  assign run_first = (found_q == '0) ? pos_q : run_start_q;
  assign mark_val  = (func_q != pba_pkg::FuncFree);
  assign pidx16    = {1'b0, req_i.page_index};

  assign accept = start & ~busy;

  // Register writes are taken only while the block is idle and no command is offered.
  assign cfg_ready_o = ~busy & ~start;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    st_d        = st_q;
    func_d      = func_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    run_start_d = run_start_q;
    phase_d     = phase_q;
    fin_d       = fin_q;
    word_d      = word_q;
    waddr_d     = waddr_q;
    first_d     = first_q;
    ok_d        = ok_q;
    hint_d      = hint_q;
    mem_we      = 1'b0;

    unique case (st_q)
      StIdle: begin
        if (accept) begin
          func_d  = req_i.func;
          phase_d = 1'b0;
          found_d = '0;
          fin_d   = 1'b0;
          first_d = '0;
          ok_d    = 1'b0;
          cnt_d   = req_i.count;
          unique case (req_i.func)
            pba_pkg::FuncAlloc: begin
              pos_d = hint_q;
              st_d  = (hint_q >= lim) ? StDone : StFetch;
            end
            pba_pkg::FuncRun: begin
              pos_d = hint_q;
              if (req_i.count == '0) begin
                // An empty run succeeds at once and touches nothing.
                ok_d = 1'b1;
                st_d = StDone;
              end else begin
                st_d = (hint_q >= lim) ? StDone : StFetch;
              end
            end
            pba_pkg::FuncLock, pba_pkg::FuncFree: begin
              pos_d   = pidx16;
              first_d = req_i.page_index;
              ok_d    = 1'b1;
              if ((req_i.count == '0) || (pidx16 >= lim)) begin
                st_d = StDone;
              end else begin
                st_d = StFetch;
                if ((req_i.func == pba_pkg::FuncFree) && (hint_q > pidx16)) begin
                  hint_d = pidx16;
                end
              end
            end
            default: st_d = StIdle;
          endcase
        end
      end

      StFetch: begin
        waddr_d = mem_addr;
        st_d    = StFill;
      end

      StFill: begin
        word_d = mem_rdata;
        st_d   = StStep;
      end

      StStep: begin
        if (func_q == pba_pkg::FuncAlloc) begin
          if (full_skip) begin
            pos_d  = skip_pos;
            hint_d = skip_pos;
            st_d   = skip_end ? StDone : StFetch;
          end else if (!cur_bit) begin
            word_d[off] = 1'b1;
            first_d     = pos_q[pba_pkg::PageW-1:0];
            ok_d        = 1'b1;
            fin_d       = 1'b1;
            st_d        = StFlush;
          end else begin
            pos_d  = np16;
            hint_d = np16;
            st_d   = np_end ? StDone : (wrap ? StFetch : StStep);
          end
        end else if ((func_q == pba_pkg::FuncRun) && !phase_q) begin
          if (full_skip) begin
            found_d = '0;
            pos_d   = skip_pos;
            hint_d  = skip_pos;
            st_d    = skip_end ? StDone : StFetch;
          end else begin
            pos_d  = np16;
            hint_d = np16;
            if (!cur_bit) begin
              found_d     = found_inc;
              run_start_d = run_first;
              if (found_inc == cnt_q) begin
                // The run is complete: walk back to its start and mark it.
                phase_d = 1'b1;
                pos_d   = run_first;
                first_d = run_first[pba_pkg::PageW-1:0];
                ok_d    = 1'b1;
                st_d    = StFetch;
              end else begin
                st_d = np_end ? StDone : (wrap ? StFetch : StStep);
              end
            end else begin
              found_d = '0;
              st_d    = np_end ? StDone : (wrap ? StFetch : StStep);
            end
          end
        end else begin
          word_d[off] = mark_val;
          cnt_d       = cnt_q - 16'd1;
          pos_d       = np16;
          if ((cnt_q == 16'd1) || np_end) begin
            fin_d = 1'b1;
            st_d  = StFlush;
          end else if (wrap) begin
            st_d = StFlush;
          end else begin
            st_d = StStep;
          end
        end
      end

      StFlush: begin
        mem_we = 1'b1;
        st_d   = fin_q ? StDone : StFetch;
      end

      StDone: begin
        st_d = StIdle;
      end

      default: st_d = StIdle;
    endcase

    // A write of start_page resets the hint.
    if (cfg_we && (cfg_index_i == pba_pkg::RegStartPage)) begin
      hint_d = cfg_data_i;
    end
  end

  always_comb begin
    total_d = total_q;
    if (cfg_we && (cfg_index_i == pba_pkg::RegTotalPages)) begin
      total_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      total_q <= pba_pkg::TotalPagesRst;
      hint_q  <= '0;
      fin_q   <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      total_q <= total_d;
      hint_q  <= hint_d;
      fin_q   <= fin_d;
      phase_q <= phase_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    pos_q       <= pos_d;
    cnt_q       <= cnt_d;
    found_q     <= found_d;
    run_start_q <= run_start_d;
    word_q      <= word_d;
    waddr_q     <= waddr_d;
    first_q     <= first_d;
    ok_q        <= ok_d;
  end

  pba_bitmap #(
    .WORDS  (Words),
    .ADDR_W (AddrW)
  ) u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_we),
    .wr_addr_i (waddr_q),
    .wr_data_i (word_q),
    .rd_addr_i (mem_addr),
    .rd_data_o (mem_rdata),
    .ready_o   (mem_ready)
  );

  assign busy             = (st_q != StIdle) | ~mem_ready;
  assign done_o           = (st_q == StDone);
  assign rsp_o.first_page = first_q;
  assign rsp_o.ok         = ok_q;

endmodule

`default_nettype wire

// ----- hdl/pba_checker.sv -----
// Port-level checks of the page bitmap allocator and their binding to the top level.
`default_nettype none

module pba_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done_o,
  input wire pba_pkg::rsp_t rsp_o
);

  // A result only appears while a transaction is in flight.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("done_o raised while the block is not busy");

  // An accepted command makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a command");

  // Each transaction gives exactly one single-cycle result.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held for more than one cycle");

  // A failed request reports page zero.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.ok) |-> (rsp_o.first_page == '0))
    else $error("failed request reports a non-zero page");

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire
